// ===== hw/rtl/dma_pkg.sv =====
// ----------------------------------------------------------------------------
// dma_pkg
// Shared widths, register map and reset values for the dual moving average.
// ----------------------------------------------------------------------------
package dma_pkg;

  // Sample and average width, unsigned Q16.16
  localparam int unsigned PRICE_W = 32;

  // Length register width and reset values
  localparam int unsigned CFG_W        = 9;
  localparam logic [CFG_W-1:0] SHORT_LEN_RST = 9'd20;
  localparam logic [CFG_W-1:0] LONG_LEN_RST  = 9'd50;

  // Register map: index of each register, byte address is 4 * index
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_SHORT_LEN = 1'b0;
  localparam logic REG_LONG_LEN  = 1'b1;

endpackage

// ===== hw/rtl/dma_div.sv =====
// ----------------------------------------------------------------------------
// dma_div
// Radix-2 restoring divider: window total over window length, one quotient
// bit per cycle, 32-bit quotient.
// ----------------------------------------------------------------------------
module dma_div #(
  parameter int unsigned TOTAL_W = 40,
  parameter int unsigned LEN_W   = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [TOTAL_W-1:0]           dividend_i,
  input  logic [LEN_W-1:0]             divisor_i,
  output logic                         busy_o,
  output logic [dma_pkg::PRICE_W-1:0]  quotient_o
);

  localparam int unsigned QW    = dma_pkg::PRICE_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] div_q;
  logic [QW-1:0]    quo_q, quo_d;
  logic [LEN_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and try a subtraction
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? LEN_W'(trial - {1'b0, div_q}) : LEN_W'(trial);
    quo_d = {quo_q[QW-2:0], ge};
  end

  // Control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: the top bits of the total are already below the length,
  // so they seed the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= LEN_W'(dividend_i[TOTAL_W-1:QW]);
      quo_q <= dividend_i[QW-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/dual_moving_average.sv =====
// ----------------------------------------------------------------------------
// dual_moving_average
// Short and long simple moving averages of a Q16.16 price stream, each kept
// in a circular sample memory with a running total.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   price_i
// out      output     out_valid_o / out_ready_i short_avg_o, long_avg_o
// cfg      input      APB psel/penable/pwrite   short_length @0x0, long_length @0x4
//
// A transaction passes in order through the sample memory read, the read-modify-write
// of memory and totals, the bit-serial dividers and the load of the output register.
// Reset empties both windows at once through a wrap flag per window; there is
// no clearing pass. A stalled output holds only the final load; the next
// transaction is accepted while the previous result waits.
// ----------------------------------------------------------------------------
module dual_moving_average #(
  parameter int unsigned MAX_WINDOW = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dma_pkg::PRICE_W-1:0]        price_i,
  // averages output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dma_pkg::PRICE_W-1:0]        short_avg_o,
  output logic [dma_pkg::PRICE_W-1:0]        long_avg_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dma_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dma_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dma_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned PW    = $clog2(MAX_WINDOW);
  localparam int unsigned LENW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TW    = dma_pkg::PRICE_W + PW;
  localparam int unsigned DW    = dma_pkg::PRICE_W;
  localparam int unsigned CW    = dma_pkg::CFG_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] short_reg_q, long_reg_q;
  logic [LENW-1:0] short_win_len, long_win_len;

  logic [DW-1:0] short_mem [MAX_WINDOW];
  logic [DW-1:0] long_mem  [MAX_WINDOW];
  logic [DW-1:0] short_rd_q, long_rd_q;
  logic [DW-1:0] price_q;

  logic [PW-1:0] short_pos_q, short_pos_d, long_pos_q, long_pos_d;
  logic          short_full_q, short_full_d, long_full_q, long_full_d;
  logic [TW-1:0] short_total_q, short_total_d, long_total_q, long_total_d;
  logic [LENW-1:0] short_nxt, long_nxt;
  logic [DW-1:0] short_old, long_old;

  logic          accept, cfg_wr, upd, out_load;
  logic          short_busy, long_busy;
  logic [DW-1:0] short_quo, long_quo;
  logic          out_valid_q;
  logic [DW-1:0] short_avg_q, long_avg_q;

  // Clamp each length register into 1..MAX_WINDOW
  always_comb begin
    if (short_reg_q == '0) begin
      short_win_len = LENW'(1);
    end else if (32'(short_reg_q) > 32'(MAX_WINDOW)) begin
      short_win_len = LENW'(MAX_WINDOW);
    end else begin
      short_win_len = LENW'(short_reg_q);
    end
    if (long_reg_q == '0) begin
      long_win_len = LENW'(1);
    end else if (32'(long_reg_q) > 32'(MAX_WINDOW)) begin
      long_win_len = LENW'(MAX_WINDOW);
    end else begin
      long_win_len = LENW'(long_reg_q);
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      dma_pkg::REG_SHORT_LEN: prdata = dma_pkg::APB_DATA_W'(short_reg_q);
      dma_pkg::REG_LONG_LEN:  prdata = dma_pkg::APB_DATA_W'(long_reg_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_reg_q <= dma_pkg::SHORT_LEN_RST;
      long_reg_q  <= dma_pkg::LONG_LEN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == dma_pkg::REG_SHORT_LEN) begin
        short_reg_q <= pwdata[CW-1:0];
      end else begin
        long_reg_q <= pwdata[CW-1:0];
      end
    end
  end

  // Sequencer
  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign upd        = (state_q == S_UPD);
  assign out_load   = (state_q == S_DIV) & ~short_busy & ~long_busy &
                      (~out_valid_q | out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_UPD;
      S_UPD:   state_d = S_DIV;
      S_DIV:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample memories: read the oldest sample on accept, overwrite it on update.
  // Read and write of one entry fall in different cycles, so nothing overlaps.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      short_rd_q <= short_mem[short_pos_q];
      long_rd_q  <= long_mem[long_pos_q];
      price_q    <= price_i;
    end
    if (upd) begin
      short_mem[short_pos_q] <= price_q;
      long_mem[long_pos_q]   <= price_q;
    end
  end

  // Update totals and positions; an entry not yet written since the window
  // was emptied reads as zero
  always_comb begin
    short_old     = short_full_q ? short_rd_q : '0;
    long_old      = long_full_q  ? long_rd_q  : '0;
    short_total_d = short_total_q - TW'(short_old) + TW'(price_q);
    long_total_d  = long_total_q  - TW'(long_old)  + TW'(price_q);
    short_nxt     = LENW'(short_pos_q) + LENW'(1);
    long_nxt      = LENW'(long_pos_q)  + LENW'(1);
    short_pos_d   = (short_nxt >= short_win_len) ? '0 : PW'(short_nxt);
    long_pos_d    = (long_nxt  >= long_win_len)  ? '0 : PW'(long_nxt);
    short_full_d  = short_full_q | (short_nxt >= short_win_len);
    long_full_d   = long_full_q  | (long_nxt  >= long_win_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_pos_q   <= '0;
      short_full_q  <= 1'b0;
      short_total_q <= '0;
      long_pos_q    <= '0;
      long_full_q   <= 1'b0;
      long_total_q  <= '0;
    end else if (cfg_wr) begin
      // Drop the window whose length is rewritten
      if (paddr[2] == dma_pkg::REG_SHORT_LEN) begin
        short_pos_q   <= '0;
        short_full_q  <= 1'b0;
        short_total_q <= '0;
      end else begin
        long_pos_q    <= '0;
        long_full_q   <= 1'b0;
        long_total_q  <= '0;
      end
    end else if (upd) begin
      short_pos_q   <= short_pos_d;
      short_full_q  <= short_full_d;
      short_total_q <= short_total_d;
      long_pos_q    <= long_pos_d;
      long_full_q   <= long_full_d;
      long_total_q  <= long_total_d;
    end
  end

  // Dividers, started with the new totals
  dma_div #(
    .TOTAL_W (TW),
    .LEN_W   (LENW)
  ) u_short_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd),
    .dividend_i (short_total_d),
    .divisor_i  (short_win_len),
    .busy_o     (short_busy),
    .quotient_o (short_quo)
  );

  dma_div #(
    .TOTAL_W (TW),
    .LEN_W   (LENW)
  ) u_long_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (upd),
    .dividend_i (long_total_d),
    .divisor_i  (long_win_len),
    .busy_o     (long_busy),
    .quotient_o (long_quo)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      short_avg_q <= short_quo;
      long_avg_q  <= long_quo;
    end
  end

  assign out_valid_o = out_valid_q;
  assign short_avg_o = short_avg_q;
  assign long_avg_o  = long_avg_q;

`ifndef SYNTHESIS
  a_accept_then_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_UPD) && short_busy == 1'b0 && long_busy == 1'b0)
    else $error("accepted transaction did not move to the update cycle");

  a_pos_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LENW'(short_pos_q) < short_win_len) && (LENW'(long_pos_q) < long_win_len))
    else $error("write position outside its window");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LENW'(short_total_q[TW-1:DW]) < short_win_len) &&
    (LENW'(long_total_q[TW-1:DW]) < long_win_len))
    else $error("running total exceeds length times largest sample");

  a_div_started : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> short_busy && long_busy && (state_q == S_DIV))
    else $error("dividers not running after update");
`endif

endmodule
